// File: design/rbsa_pkg.sv
package rbsa_pkg;

    localparam int MAX_DEVICES = 64;
    localparam int IDX_W = $clog2(MAX_DEVICES);
    localparam int CNT_W = $clog2(MAX_DEVICES + 1);
    localparam int PWR_W = 13;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_PERCENT = 3'd7;

    // Allocation modes.
    localparam logic [3:0] MODE_SF7      = 4'd1;
    localparam logic [3:0] MODE_SF12     = 4'd2;
    localparam logic [3:0] MODE_SIXTHS   = 4'd3;
    localparam logic [3:0] MODE_CAP      = 4'd4;
    localparam logic [3:0] MODE_COV      = 4'd5;
    localparam logic [3:0] MODE_RATE     = 4'd6;
    localparam logic [3:0] MODE_CAP_GATE = 4'd7;
    localparam logic [3:0] MODE_COV_GATE = 4'd8;
    localparam logic [3:0] MODE_REALLOC  = 4'd10;

    // One entry travelling along the sorting chain.
    typedef struct packed {
        logic                    valid;
        logic signed [PWR_W-1:0] power;
        logic [IDX_W-1:0]        index;
    } entry_t;

    // Strict ordering: stronger power first, equal power lower index first.
    function automatic logic ahead_of(input entry_t a, input entry_t b);
        if (!b.valid) begin
            return a.valid;
        end
        if (!a.valid) begin
            return 1'b0;
        end
        return (a.power > b.power) || (a.power == b.power && a.index < b.index);
    endfunction

endpackage

// File: design/rank_based_sf_allocator.sv
// Rank-based spreading-factor allocator. Power samples are taken one per
// cycle, the best sample of each device is kept, and when a device closes it
// is inserted into a sorted chain of MAX_DEVICES cells, so loading runs at one
// sample per clock. After the sample with last_device the chain shifts toward
// its head, one result per cycle as the output is taken; results leave
// strongest first with rank, data rate and spreading factor.
// A new sample is refused while results of a run are still going out.
// Configuration writes are accepted at any time but must be made while idle.
module rank_based_sf_allocator
    import rbsa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [PWR_W-1:0] s_rx_power,
    input  logic                    s_last_gateway,
    input  logic                    s_last_device,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_W-1:0]        m_device_index,
    output logic [IDX_W-1:0]        m_rank,
    output logic [2:0]              m_data_rate,
    output logic [3:0]              m_spreading_factor,
    output logic                    m_overflow,
    output logic                    m_last,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [15:0]             cfg_data
);

    logic [3:0]              mode_reg;
    logic signed [PWR_W-1:0] sens_reg [6];
    logic [6:0]              pct_reg;

    logic signed [PWR_W-1:0] best_reg;
    logic                    first_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    ovf_reg;
    logic                    emit_reg;
    logic [IDX_W-1:0]        rank_reg;

    logic signed [PWR_W-1:0] best_next;
    logic                    s_fire, m_fire, close, insert, shift, clear;
    entry_t                  new_entry;
    entry_t                  held [MAX_DEVICES];
    logic                    disp [MAX_DEVICES];
    logic [2:0]              dr;
    logic [3:0]              sf;

    assign cfg_ready = 1'b1;
    assign s_ready   = !emit_reg;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = emit_reg;
    assign m_fire    = m_valid && m_ready;
    assign close     = s_fire && (s_last_gateway || s_last_device);

    // Running maximum of the current device's samples.
    assign best_next = (first_reg || s_rx_power > best_reg) ? s_rx_power : best_reg;
    assign insert    = close && count_reg < CNT_W'(MAX_DEVICES);
    assign shift     = m_fire;
    assign clear     = 1'b0;

    always_comb begin
        new_entry.valid = 1'b1;
        new_entry.power = best_next;
        new_entry.index = IDX_W'(count_reg);
    end

    // Sorted chain of cells.
    for (genvar g = 0; g < MAX_DEVICES; g++) begin : g_chain
        entry_t ph, nh;
        logic   pd;
        if (g == 0) begin : g_head
            assign ph = '0;
            assign pd = 1'b0;
        end else begin : g_body
            assign ph = held[g-1];
            assign pd = disp[g-1];
        end
        if (g == MAX_DEVICES - 1) begin : g_tail
            assign nh = '0;
        end else begin : g_mid
            assign nh = held[g+1];
        end
        rbsa_cell u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .insert         (insert),
            .shift          (shift),
            .clear          (clear),
            .new_entry      (new_entry),
            .prev_held      (ph),
            .prev_displaced (pd),
            .next_held      (nh),
            .held           (held[g]),
            .displaced      (disp[g])
        );
    end

    rbsa_sf_calc u_sf (
        .alloc_mode       (mode_reg),
        .sens             (sens_reg),
        .realloc_percent  (pct_reg),
        .power            (held[0].power),
        .rank             (rank_reg),
        .count            (count_reg),
        .data_rate        (dr),
        .spreading_factor (sf)
    );

    assign m_device_index     = held[0].index;
    assign m_rank             = rank_reg;
    assign m_data_rate        = dr;
    assign m_spreading_factor = sf;
    assign m_overflow         = ovf_reg;
    assign m_last             = (CNT_W'(rank_reg) + CNT_W'(1)) == count_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_SF7;
            sens_reg[0] <= -13'sd1984;
            sens_reg[1] <= -13'sd2032;
            sens_reg[2] <= -13'sd2080;
            sens_reg[3] <= -13'sd2128;
            sens_reg[4] <= -13'sd2160;
            sens_reg[5] <= -13'sd2192;
            pct_reg     <= 7'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:    mode_reg <= cfg_data[3:0];
                REG_PERCENT: pct_reg  <= cfg_data[6:0];
                default:     sens_reg[cfg_index - 3'd1] <= cfg_data[PWR_W-1:0];
            endcase
        end
    end

    // Load and emission control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg  <= '0;
            first_reg <= 1'b1;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            emit_reg  <= 1'b0;
            rank_reg  <= '0;
        end else if (emit_reg) begin
            if (m_fire) begin
                rank_reg <= rank_reg + IDX_W'(1);
                if (m_last) begin
                    emit_reg  <= 1'b0;
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    rank_reg  <= '0;
                end
            end
        end else if (s_fire) begin
            best_reg  <= close ? '0 : best_next;
            first_reg <= close;
            if (insert) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (close) begin
                ovf_reg <= 1'b1;
            end
            if (s_last_device) begin
                emit_reg <= 1'b1;
            end
        end
    end

`ifndef SYNTH
    // No samples are taken during emission.
    a_no_load_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_reg |-> !s_ready) else $error("sample taken during emission");
    // Device count never exceeds capacity.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_DEVICES)) else $error("device count overflow");
    // Ranks advance by one per result.
    a_rank_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && !m_last) |=> rank_reg == $past(rank_reg) + IDX_W'(1))
        else $error("rank skipped");
    // The chain head is ordered ahead of its neighbor.
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        held[1].valid |-> ahead_of(held[0], held[1])) else $error("chain unsorted");
`endif

endmodule

// File: design/rbsa_cell.sv
module rbsa_cell
    import rbsa_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   insert,
    input  logic   shift,
    input  logic   clear,
    input  entry_t new_entry,
    input  entry_t prev_held,
    input  logic   prev_displaced,
    input  entry_t next_held,
    output entry_t held,
    output logic   displaced
);

    entry_t held_reg;
    entry_t held_next;

    // This cell's entry moves down when the new entry ranks ahead of it.
    assign displaced = ahead_of(new_entry, held_reg);
    assign held      = held_reg;

    // Clearing empties the cell, insertion keeps the chain sorted and shifting moves it toward the head.
    always_comb begin
        held_next = held_reg;
        if (clear) begin
            held_next = '0;
        end else if (shift) begin
            held_next = next_held;
        end else if (insert && displaced) begin
            held_next = prev_displaced ? prev_held : new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_next;
        end
    end

endmodule

// File: design/rbsa_sf_calc.sv
module rbsa_sf_calc
    import rbsa_pkg::*;
(
    input  logic [3:0]              alloc_mode,
    input  logic signed [PWR_W-1:0] sens [6],
    input  logic [6:0]              realloc_percent,
    input  logic signed [PWR_W-1:0] power,
    input  logic [IDX_W-1:0]        rank,
    input  logic [CNT_W-1:0]        count,
    output logic [2:0]              data_rate,
    output logic [3:0]              spreading_factor
);

    logic [CNT_W+4:0] r20;
    logic [CNT_W+4:0] cap_lim [5];
    logic [CNT_W+4:0] cov_lim [5];
    logic [CNT_W+2:0] r6;
    logic [CNT_W+2:0] six_lim [5];
    logic [IDX_W+6:0] r100;
    logic [CNT_W+6:0] pct_n;
    logic [3:0]       sf_cap, sf_cov, sf_capg, sf_covg, sf_six, sf_rate;
    logic [4:0]       gate;

    // Rate from thresholds; the strongest threshold passed wins.
    always_comb begin
        data_rate = 3'd0;
        for (int k = 5; k >= 0; k--) begin
            if (power > sens[k]) begin
                data_rate = 3'(5 - k);
            end
        end
    end

    // Exact rank fraction compares, done in integer multiples.
    always_comb begin
        r20 = (CNT_W+5)'(rank) * (CNT_W+5)'(20);
        r6  = (CNT_W+3)'(rank) * (CNT_W+3)'(6);
        cap_lim[0] = (CNT_W+5)'(count) * (CNT_W+5)'(12);
        cap_lim[1] = (CNT_W+5)'(count) * (CNT_W+5)'(16);
        cap_lim[2] = (CNT_W+5)'(count) * (CNT_W+5)'(17);
        cap_lim[3] = (CNT_W+5)'(count) * (CNT_W+5)'(18);
        cap_lim[4] = (CNT_W+5)'(count) * (CNT_W+5)'(19);
        cov_lim[0] = (CNT_W+5)'(count);
        cov_lim[1] = (CNT_W+5)'(count) * (CNT_W+5)'(2);
        cov_lim[2] = (CNT_W+5)'(count) * (CNT_W+5)'(3);
        cov_lim[3] = (CNT_W+5)'(count) * (CNT_W+5)'(4);
        cov_lim[4] = (CNT_W+5)'(count) * (CNT_W+5)'(8);
        // r < floor(k*n/6) is the same as 6r <= k*n - 6 when k*n >= 6.
        for (int k = 0; k < 5; k++) begin
            six_lim[k] = (CNT_W+3)'(count) * (CNT_W+3)'(k + 1);
            gate[k]    = power > sens[k];
        end
        r100  = (IDX_W+7)'(rank) * (IDX_W+7)'(100);
        pct_n = (CNT_W+7)'(realloc_percent) * (CNT_W+7)'(count);
        sf_cap = 4'd12;  sf_cov = 4'd12;  sf_capg = 4'd12;  sf_covg = 4'd12;
        sf_six = 4'd12;
        for (int k = 4; k >= 0; k--) begin
            if (r20 < cap_lim[k]) sf_cap = 4'(7 + k);
            if (r20 < cov_lim[k]) sf_cov = 4'(7 + k);
            if (r20 < cap_lim[k] && gate[k]) sf_capg = 4'(7 + k);
            if (r20 < cov_lim[k] && gate[k]) sf_covg = 4'(7 + k);
            if (six_lim[k] >= (CNT_W+3)'(6) && r6 + (CNT_W+3)'(6) <= six_lim[k]) begin
                sf_six = 4'(7 + k);
            end
        end
        sf_rate = 4'd12 - 4'(data_rate);
    end

    // Mode select.
    always_comb begin
        case (alloc_mode)
            MODE_SF7:      spreading_factor = 4'd7;
            MODE_SF12:     spreading_factor = 4'd12;
            MODE_SIXTHS:   spreading_factor = sf_six;
            MODE_CAP:      spreading_factor = sf_cap;
            MODE_COV:      spreading_factor = sf_cov;
            MODE_RATE:     spreading_factor = sf_rate;
            MODE_CAP_GATE: spreading_factor = sf_capg;
            MODE_COV_GATE: spreading_factor = sf_covg;
            MODE_REALLOC: begin
                if ((CNT_W+7)'(r100) < pct_n && sf_rate > 4'd7) begin
                    spreading_factor = sf_rate - 4'd1;
                end else begin
                    spreading_factor = sf_rate;
                end
            end
            default:       spreading_factor = 4'd0;
        endcase
    end

endmodule
